/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/itp_pkg.sv */
// Package for the infix-to-postfix converter: stack sizing, operator codes,
// precedence tables, state type and the stack command/status structs. No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [2:0] op_code_t;

    localparam op_code_t OP_LPAREN = 3'd0;
    localparam op_code_t OP_PLUS   = 3'd1;
    localparam op_code_t OP_MINUS  = 3'd2;
    localparam op_code_t OP_MUL    = 3'd3;
    localparam op_code_t OP_DIV    = 3'd4;
    localparam op_code_t OP_POW    = 3'd5;
    localparam op_code_t OP_NONE   = 3'd7;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_Z      = 8'h7A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef logic [1:0] status_t;

    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_OVERFLOW = 2'd1;
    localparam status_t STAT_UNKNOWN  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_FILL
    } itp_state_t;

    typedef struct packed {
        logic     push;
        logic     pop;
        logic     clear;
        logic     refill;
        op_code_t code;
    } stk_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] opcnt;
        op_code_t         top;
        op_code_t         rdata;
    } stk_stat_t;

    function automatic op_code_t op_classify(input logic [7:0] ch);
        op_code_t code;
        case (ch)
            CH_LPAREN: code = OP_LPAREN;
            CH_PLUS:   code = OP_PLUS;
            CH_MINUS:  code = OP_MINUS;
            CH_MUL:    code = OP_MUL;
            CH_DIV:    code = OP_DIV;
            CH_POW:    code = OP_POW;
            default:   code = OP_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] op_char(input op_code_t code);
        logic [7:0] ch;
        case (code)
            OP_LPAREN: ch = CH_LPAREN;
            OP_PLUS:   ch = CH_PLUS;
            OP_MINUS:  ch = CH_MINUS;
            OP_MUL:    ch = CH_MUL;
            OP_DIV:    ch = CH_DIV;
            OP_POW:    ch = CH_POW;
            default:   ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Precedence of an operator already on the stack.
    function automatic logic [2:0] in_stack_prec(input op_code_t code);
        logic [2:0] p;
        case (code)
            OP_PLUS, OP_MINUS: p = 3'd1;
            OP_MUL, OP_DIV:    p = 3'd2;
            OP_POW:            p = 3'd3;
            default:           p = 3'd0;
        endcase
        return p;
    endfunction

    // Precedence of an arriving operator; ^ beats its own stacked copy.
    function automatic logic [2:0] incoming_prec(input op_code_t code);
        logic [2:0] p;
        case (code)
            OP_PLUS, OP_MINUS: p = 3'd1;
            OP_MUL, OP_DIV:    p = 3'd2;
            OP_POW:            p = 3'd4;
            default:           p = 3'd5;
        endcase
        return p;
    endfunction

endpackage

/* rtl/infix_to_postfix_converter.sv */
// Channel  Dir  Payload                                   Accepted when
// s_*      in   tdata: char_in; tlast: end_of_expr        s_tvalid && s_tready
// m_*      out  tdata: char_out; tlast: last_in_run;      m_tvalid && m_tready
//               tuser: expr_done, status
//
// A letter, an unknown character or a push is taken in ST_IDLE and acted on in
// ST_WORK. A pop that leaves entries on the stack is followed by ST_FILL, in which
// the stack memory returns the new top entry. The stack memory is not cleared
// on reset; only the depth and operator counts are. A full output register
// stalls the work, and a new request is taken only when the previous one is done.
// Top level: sequencer and output register; depends on itp_pkg and itp_stack.
`timescale 1ns / 1ps

module infix_to_postfix_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast,
    output logic [2:0] m_tuser    // [0] expr_done, [2:1] status
);
    import itp_pkg::*;

    itp_state_t state_reg, state_next;
    logic [7:0] ch_reg, ch_next;
    logic       end_reg, end_next;
    op_code_t   code_reg, code_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_char_reg, pend_char_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic [2:0] m_tuser_reg, m_tuser_next;

    stk_cmd_t   cmd;
    stk_stat_t  stat;

    logic       out_free;
    logic       emit;
    logic [7:0] e_char;
    logic       e_last;
    logic       e_done;
    status_t    e_stat;
    logic       is_letter;
    logic       more;

    itp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_letter = (ch_reg >= CH_A) && (ch_reg <= CH_Z);

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        end_next        = end_reg;
        code_next       = code_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        cmd             = '0;
        emit            = 1'b0;
        e_char          = CH_NUL;
        e_last          = 1'b0;
        e_done          = 1'b0;
        e_stat          = STAT_OK;
        more            = 1'b0;
        s_tready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ch_next    = s_tdata;
                    end_next   = s_tlast;
                    code_next  = op_classify(s_tdata);
                    state_next = ST_WORK;
                end
            end

            ST_WORK:
            begin
                if (out_free)
                begin
                    if (end_reg)
                    begin
                        if (stat.opcnt == '0)
                        begin
                            // Only parentheses left (or nothing): drop them at once.
                            cmd.clear  = 1'b1;
                            state_next = ST_IDLE;
                            emit       = 1'b1;
                            e_last     = 1'b1;
                            e_done     = 1'b1;
                        end
                        else if (stat.top == OP_LPAREN)
                        begin
                            cmd.pop         = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = ST_FILL;
                        end
                        else if (stat.opcnt == CNT_W'(1))
                        begin
                            cmd.clear  = 1'b1;
                            emit       = 1'b1;
                            e_char     = op_char(stat.top);
                            e_last     = 1'b1;
                            e_done     = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.pop         = 1'b1;
                            emit            = 1'b1;
                            e_char          = op_char(stat.top);
                            pend_valid_next = 1'b0;
                            state_next      = ST_FILL;
                        end
                    end
                    else if (is_letter)
                    begin
                        emit       = 1'b1;
                        e_char     = ch_reg;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (ch_reg == CH_RPAREN)
                    begin
                        if (stat.count == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.pop = 1'b1;
                            if (stat.top == OP_LPAREN)
                            begin
                                pend_valid_next = 1'b0;
                                state_next = (stat.count >= CNT_W'(2)) ? ST_FILL : ST_IDLE;
                            end
                            else if (stat.count >= CNT_W'(2))
                            begin
                                pend_valid_next = 1'b1;
                                pend_char_next  = op_char(stat.top);
                                state_next      = ST_FILL;
                            end
                            else
                            begin
                                emit       = 1'b1;
                                e_char     = op_char(stat.top);
                                e_last     = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    else if (code_reg != OP_NONE)
                    begin
                        if ((stat.count != '0) &&
                            (in_stack_prec(stat.top) >= incoming_prec(code_reg)))
                        begin
                            cmd.pop = 1'b1;
                            if (stat.count >= CNT_W'(2))
                            begin
                                pend_valid_next = 1'b1;
                                pend_char_next  = op_char(stat.top);
                                state_next      = ST_FILL;
                            end
                            else
                            begin
                                // Stack empties, so the push that follows is certain.
                                emit   = 1'b1;
                                e_char = op_char(stat.top);
                                e_last = 1'b1;
                            end
                        end
                        else if (stat.count < CNT_W'(STACK_DEPTH))
                        begin
                            cmd.push   = 1'b1;
                            cmd.code   = code_reg;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            e_last     = 1'b1;
                            e_stat     = STAT_OVERFLOW;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        emit       = 1'b1;
                        e_last     = 1'b1;
                        e_stat     = STAT_UNKNOWN;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FILL:
            begin
                cmd.refill = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = end_reg ? ST_WORK : ST_IDLE;
                end
                else if (out_free)
                begin
                    // The new top tells whether the held operator is the last result.
                    if (ch_reg == CH_RPAREN)
                    begin
                        more = (stat.rdata != OP_LPAREN);
                    end
                    else
                    begin
                        more = (in_stack_prec(stat.rdata) >= incoming_prec(code_reg));
                    end
                    emit            = 1'b1;
                    e_char          = pend_char_reg;
                    e_last          = !more;
                    pend_valid_next = 1'b0;
                    state_next      = ST_WORK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = e_char;
            m_tlast_next  = e_last;
            m_tuser_next  = {e_stat, e_done};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        end_reg       <= end_next;
        code_reg      <= code_next;
        pend_char_reg <= pend_char_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/itp_stack.sv */
// Operator stack of the converter: synchronous memory, depth count, operator
// count and a cached top entry. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_stack (
    input  logic               clk,
    input  logic               rst_n,
    input  itp_pkg::stk_cmd_t  cmd,
    output itp_pkg::stk_stat_t stat
);
    import itp_pkg::*;

    op_code_t         mem [STACK_DEPTH];
    op_code_t         rdata_reg;
    op_code_t         top_reg;
    op_code_t         top_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] opcnt_reg;
    logic [CNT_W-1:0] opcnt_next;
    logic [CNT_W-1:0] rd_idx;
    logic             rd_en;

    // A pop leaving entries fetches the one below the top; control waits in ST_FILL
    // for it before looking at the stack again, so reads and writes never overlap.
    assign rd_idx = count_reg - CNT_W'(2);
    assign rd_en  = cmd.pop && (count_reg >= CNT_W'(2));

    always_comb
    begin
        count_next = count_reg;
        opcnt_next = opcnt_reg;
        top_next   = top_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            opcnt_next = '0;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            if (top_reg != OP_LPAREN)
            begin
                opcnt_next = opcnt_reg - CNT_W'(1);
            end
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            top_next   = cmd.code;
            if (cmd.code != OP_LPAREN)
            begin
                opcnt_next = opcnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.refill)
        begin
            top_next = rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            opcnt_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            opcnt_reg <= opcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.push)
        begin
            mem[count_reg[STACK_AW-1:0]] <= cmd.code;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx[STACK_AW-1:0]];
        end
    end

    assign stat.count = count_reg;
    assign stat.opcnt = opcnt_reg;
    assign stat.top   = top_reg;
    assign stat.rdata = rdata_reg;

endmodule

/* rtl/itp_checker.sv */
// Port-level checker for the infix-to-postfix converter, bound to the top level.
// Depends on itp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,   // [7:0] char_out
    input logic       m_tlast,
    input logic [2:0] m_tuser    // [0] expr_done, [2:1] status
);
    import itp_pkg::*;

    logic        err_res;
    logic        err_shape;
    logic [11:0] out_word;

    assign err_res   = m_tvalid && (m_tuser[2:1] != STAT_OK);
    assign err_shape = (m_tdata == CH_NUL) && m_tlast && !m_tuser[0];
    assign out_word  = {m_tdata, m_tlast, m_tuser};

    // A finished expression always closes the run of its request.
    `ITP_ASSERT_IMP(a_done_is_last, clk, rst_n, m_tvalid && m_tuser[0], m_tlast)

    // Error results carry no character and stand alone.
    `ITP_ASSERT_IMP(a_err_alone, clk, rst_n, err_res, err_shape)

    // One request at a time: nothing is taken in the cycle after a request.
    `ITP_ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A stalled result holds.
    `ITP_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);
